// ===== design/yuyv_to_rgb888_converter_macros.svh =====
// Assertion macros shared by the converter RTL.
`ifndef YUYV_TO_RGB888_CONVERTER_MACROS_SVH
`define YUYV_TO_RGB888_CONVERTER_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a condition in the same cycle as its trigger.
`define YRGB_ASSERT_IMP(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("yuyv_to_rgb888_converter: assertion failed");
// Check a condition in the cycle after its trigger.
`define YRGB_ASSERT_NXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("yuyv_to_rgb888_converter: assertion failed");
`else
`define YRGB_ASSERT_IMP(lbl, trig, cond)
`define YRGB_ASSERT_NXT(lbl, trig, cond)
`endif
`endif

// ===== design/yrgb_pkg.sv =====
package yrgb_pkg;

  localparam int NPIX   = 2;
  localparam int NCH    = 3;
  localparam int PROD_W = 25;   // signed coef * (chroma - 128)
  localparam int SUM_W  = 26;   // signed luma * 2^16 +/- products
  localparam int FRAC_W = 16;

  // channel index within one pixel
  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic [SUM_W-1:0]         sum_t;
  typedef logic [7:0]               byte_t;

  // Coefficients, unsigned Q.16 rounded to nearest
  localparam prod_t COEF_RED_V   = 25'sd89831;
  localparam prod_t COEF_GREEN_V = 25'sd45744;
  localparam prod_t COEF_GREEN_U = 25'sd22127;
  localparam prod_t COEF_BLUE_U  = 25'sd113538;

  localparam logic [15:0] SCALE_NUM = 16'd220;

  typedef struct packed {
    prod_t                 red_v;
    prod_t                 green_v;
    prod_t                 green_u;
    prod_t                 blue_u;
    byte_t [NPIX-1:0]      luma;
    logic                  eof;
  } prod_stage_t;

  typedef struct packed {
    sum_t [NPIX-1:0][NCH-1:0] sum;
    logic                     eof;
  } sum_stage_t;

  typedef struct packed {
    byte_t [NPIX-1:0][NCH-1:0] ch;
    logic                      eof;
  } pix_stage_t;

endpackage

// ===== design/yrgb_chroma_mul.sv =====
module yrgb_chroma_mul
  import yrgb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  byte_t       luma_first,
  input  byte_t       chroma_blue,
  input  byte_t       luma_second,
  input  byte_t       chroma_red,
  input  logic        end_of_frame,
  output logic        out_valid,
  input  logic        out_ready,
  output prod_stage_t out_data
);

  logic        valid_r;
  prod_stage_t data_r;
  prod_stage_t data_nxt;
  prod_t       du;
  prod_t       dv;

  assign in_ready = !valid_r || out_ready;

  // Remove the chroma offset by flipping the top bit, then sign extend.
  always_comb begin
    du = PROD_W'($signed(chroma_blue ^ 8'h80));
    dv = PROD_W'($signed(chroma_red ^ 8'h80));
    data_nxt.red_v   = dv * COEF_RED_V;
    data_nxt.green_v = dv * COEF_GREEN_V;
    data_nxt.green_u = du * COEF_GREEN_U;
    data_nxt.blue_u  = du * COEF_BLUE_U;
    data_nxt.luma[0] = luma_first;
    data_nxt.luma[1] = luma_second;
    data_nxt.eof     = end_of_frame;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== design/yrgb_sum.sv =====
module yrgb_sum
  import yrgb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  prod_stage_t in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output sum_stage_t  out_data
);

  logic       valid_r;
  sum_stage_t data_r;
  sum_stage_t data_nxt;
  sum_t       base;
  sum_t       red_x;
  sum_t       green_vx;
  sum_t       green_ux;
  sum_t       blue_x;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    red_x    = SUM_W'($signed(in_data.red_v));
    green_vx = SUM_W'($signed(in_data.green_v));
    green_ux = SUM_W'($signed(in_data.green_u));
    blue_x   = SUM_W'($signed(in_data.blue_u));
    base     = '0;
    for (int p = 0; p < NPIX; p++) begin
      base = {2'b00, in_data.luma[p], {FRAC_W{1'b0}}};
      data_nxt.sum[p][CH_RED]   = base + red_x;
      data_nxt.sum[p][CH_GREEN] = base - green_vx - green_ux;
      data_nxt.sum[p][CH_BLUE]  = base + blue_x;
    end
    data_nxt.eof = in_data.eof;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== design/yrgb_clamp.sv =====
module yrgb_clamp
  import yrgb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  sum_stage_t in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output pix_stage_t out_data
);

  logic       valid_r;
  pix_stage_t data_r;
  pix_stage_t data_nxt;
  sum_t       s;

  assign in_ready = !valid_r || out_ready;

  // Negative sums go to zero; integer parts of 256 and up saturate.
  always_comb begin
    s = '0;
    for (int p = 0; p < NPIX; p++) begin
      for (int c = 0; c < NCH; c++) begin
        s = in_data.sum[p][c];
        if (s[SUM_W-1]) begin
          data_nxt.ch[p][c] = 8'd0;
        end else if (s[FRAC_W+8]) begin
          data_nxt.ch[p][c] = 8'd255;
        end else begin
          data_nxt.ch[p][c] = s[FRAC_W+7:FRAC_W];
        end
      end
    end
    data_nxt.eof = in_data.eof;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== design/yrgb_scale.sv =====
module yrgb_scale
  import yrgb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  pix_stage_t in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output pix_stage_t out_data
);

  logic        valid_r;
  pix_stage_t  data_r;
  pix_stage_t  data_nxt;
  logic [15:0] prod;

  assign in_ready = !valid_r || out_ready;

  // Scale by 220/256 with a floor.
  always_comb begin
    prod = '0;
    for (int p = 0; p < NPIX; p++) begin
      for (int c = 0; c < NCH; c++) begin
        prod = {8'h00, in_data.ch[p][c]} * SCALE_NUM;
        data_nxt.ch[p][c] = prod[15:8];
      end
    end
    data_nxt.eof = in_data.eof;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== design/yuyv_to_rgb888_converter.sv =====
// Throughput: one YUYV word per cycle while out_ready stays high; the four
//   register stages each take a new word whenever their own slot is empty
//   or moves on in the same cycle.
// Reset: synchronous, active-low rst_n clears all stage valid bits; the data
//   registers are not reset.
`include "yuyv_to_rgb888_converter_macros.svh"
module yuyv_to_rgb888_converter
  import yrgb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic [7:0] in_luma_first,
  input  logic [7:0] in_chroma_blue,
  input  logic [7:0] in_luma_second,
  input  logic [7:0] in_chroma_red,
  input  logic in_end_of_frame,
  output logic out_valid,
  input  logic out_ready,
  output logic [7:0] out_red_first,
  output logic [7:0] out_green_first,
  output logic [7:0] out_blue_first,
  output logic [7:0] out_red_second,
  output logic [7:0] out_green_second,
  output logic [7:0] out_blue_second,
  output logic out_end_of_frame_out
);

  // Stage handshake wires. Each stage holds its slot while the next stage
  // stalls and refills it as soon as the slot frees up, so bubbles collapse.
  logic        mul_valid;
  logic        mul_ready;
  prod_stage_t mul_data;
  logic        sum_valid;
  logic        sum_ready;
  sum_stage_t  sum_data;
  logic        clp_valid;
  logic        clp_ready;
  pix_stage_t  clp_data;
  pix_stage_t  scl_data;

  // Stage 1: remove chroma offset and form the four chroma products.
  yrgb_chroma_mul u_mul (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .luma_first   (in_luma_first),
    .chroma_blue  (in_chroma_blue),
    .luma_second  (in_luma_second),
    .chroma_red   (in_chroma_red),
    .end_of_frame (in_end_of_frame),
    .out_valid    (mul_valid),
    .out_ready    (mul_ready),
    .out_data     (mul_data)
  );

  // Stage 2: add luma in Q.16 to the shared products for both pixels.
  yrgb_sum u_sum (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mul_valid),
    .in_ready  (mul_ready),
    .in_data   (mul_data),
    .out_valid (sum_valid),
    .out_ready (sum_ready),
    .out_data  (sum_data)
  );

  // Stage 3: drop the fraction and clamp each channel to 0..255.
  yrgb_clamp u_clamp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sum_valid),
    .in_ready  (sum_ready),
    .in_data   (sum_data),
    .out_valid (clp_valid),
    .out_ready (clp_ready),
    .out_data  (clp_data)
  );

  // Stage 4: scale to 0..219; this is the output register.
  yrgb_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (clp_valid),
    .in_ready  (clp_ready),
    .in_data   (clp_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (scl_data)
  );

  // Unpack the result transaction onto the ports.
  assign out_red_first        = scl_data.ch[0][CH_RED];
  assign out_green_first      = scl_data.ch[0][CH_GREEN];
  assign out_blue_first       = scl_data.ch[0][CH_BLUE];
  assign out_red_second       = scl_data.ch[1][CH_RED];
  assign out_green_second     = scl_data.ch[1][CH_GREEN];
  assign out_blue_second      = scl_data.ch[1][CH_BLUE];
  assign out_end_of_frame_out = scl_data.eof;

  // The pipeline comes out of reset empty.
  `YRGB_ASSERT_IMP(a_empty_after_reset, $past(!rst_n), !out_valid)
  // With the output slot free, the whole chain must be able to take a word.
  `YRGB_ASSERT_IMP(a_no_stall_when_drained, !out_valid || out_ready, in_ready)
  // Scaled channels never exceed 219.
  `YRGB_ASSERT_IMP(a_scaled_range, out_valid,
    out_red_first <= 8'd219 && out_green_first <= 8'd219 && out_blue_first <= 8'd219 &&
    out_red_second <= 8'd219 && out_green_second <= 8'd219 && out_blue_second <= 8'd219)

endmodule

// ===== tb/sv/tb_yuyv_to_rgb888_converter.sv =====
module tb_yuyv_to_rgb888_converter;
  timeunit 1ns;
  timeprecision 1ps;

  // Fixed-point color matrix: unsigned, 16 fractional bits, rounded to nearest.
  localparam longint RED_FROM_V   = 89831;   // 1.370705
  localparam longint GREEN_FROM_V = 45744;   // 0.698001
  localparam longint GREEN_FROM_U = 22127;   // 0.337633
  localparam longint BLUE_FROM_U  = 113538;  // 1.732446
  localparam int     FRAC_BITS    = 16;
  localparam longint CHROMA_MID   = 128;
  localparam longint OUT_SCALE    = 220;     // output range squeezed by 220/256

  localparam int HOLDOFF_CYCLES = 300;   // long receiver hold-off under pressure
  localparam int STALL_LIMIT    = 4000;  // cycles without any transaction
  localparam int SETTLE_CYCLES  = 12;    // pipeline is 4 deep; allow some slack
  localparam int REPORT_LIMIT   = 10;

  typedef yrgb_pkg::byte_t byte_t;

  // One packed YUYV word as it enters the block.
  typedef struct {
    byte_t luma_first;
    byte_t chroma_blue;
    byte_t luma_second;
    byte_t chroma_red;
    logic  end_of_frame;
  } yuyv_word_t;

  // Two RGB pixels sharing one chroma pair, as they leave the block.
  typedef struct {
    byte_t red_first;
    byte_t green_first;
    byte_t blue_first;
    byte_t red_second;
    byte_t green_second;
    byte_t blue_second;
    logic  end_of_frame;
  } rgb_pair_t;

  // Scoreboard: convert every accepted word, then match results in order.
  class rgb_pair_scoreboard;
    rgb_pair_t pending_pairs[$];
    int        bad_pairs;
    int        stray_pairs;

    function byte_t clamp_and_scale(longint acc);
      longint level;
      // A negative sum truncates toward zero and clamps to black.
      if (acc < 0) return '0;
      level = acc >>> FRAC_BITS;
      if (level > 255) level = 255;
      return byte_t'((level * OUT_SCALE) >> 8);
    endfunction

    function void tint_pixel(byte_t luma, longint du, longint dv,
                             output byte_t red, output byte_t green,
                             output byte_t blue);
      longint base;
      base  = longint'(luma) <<< FRAC_BITS;
      red   = clamp_and_scale(base + RED_FROM_V * dv);
      green = clamp_and_scale(base - GREEN_FROM_V * dv - GREEN_FROM_U * du);
      blue  = clamp_and_scale(base + BLUE_FROM_U * du);
    endfunction

    function rgb_pair_t convert_word(yuyv_word_t w);
      rgb_pair_t p;
      longint    du;
      longint    dv;
      du = longint'(w.chroma_blue) - CHROMA_MID;
      dv = longint'(w.chroma_red) - CHROMA_MID;
      tint_pixel(w.luma_first, du, dv, p.red_first, p.green_first, p.blue_first);
      tint_pixel(w.luma_second, du, dv, p.red_second, p.green_second, p.blue_second);
      p.end_of_frame = w.end_of_frame;
      return p;
    endfunction

    function void note_word(yuyv_word_t w);
      pending_pairs.push_back(convert_word(w));
    endfunction

    function void check_pair(rgb_pair_t got);
      rgb_pair_t want;
      if (pending_pairs.size() == 0) begin
        stray_pairs++;
        if (bad_pairs + stray_pairs <= REPORT_LIMIT)
          $display("%0t: result with nothing pending: %0d %0d %0d / %0d %0d %0d eof %b",
                   $realtime, got.red_first, got.green_first, got.blue_first,
                   got.red_second, got.green_second, got.blue_second, got.end_of_frame);
        return;
      end
      want = pending_pairs.pop_front();
      if (got.red_first !== want.red_first || got.green_first !== want.green_first ||
          got.blue_first !== want.blue_first || got.red_second !== want.red_second ||
          got.green_second !== want.green_second ||
          got.blue_second !== want.blue_second ||
          got.end_of_frame !== want.end_of_frame) begin
        bad_pairs++;
        if (bad_pairs + stray_pairs <= REPORT_LIMIT) begin
          $display("%0t: pixel pair mismatch, expected %0d %0d %0d / %0d %0d %0d eof %b",
                   $realtime, want.red_first, want.green_first, want.blue_first,
                   want.red_second, want.green_second, want.blue_second, want.end_of_frame);
          $display("%0t: pixel pair mismatch, got %0d %0d %0d / %0d %0d %0d eof %b",
                   $realtime, got.red_first, got.green_first, got.blue_first,
                   got.red_second, got.green_second, got.blue_second, got.end_of_frame);
        end
      end
    endfunction

    function int failures();
      if (pending_pairs.size() != 0)
        $display("%0d pixel pairs never arrived", pending_pairs.size());
      return bad_pairs + stray_pairs + pending_pairs.size();
    endfunction
  endclass

  logic  clk;
  logic  rst_n;
  logic  in_valid;
  logic  in_ready;
  byte_t in_luma_first;
  byte_t in_chroma_blue;
  byte_t in_luma_second;
  byte_t in_chroma_red;
  logic  in_end_of_frame;
  logic  out_valid;
  logic  out_ready;
  byte_t out_red_first;
  byte_t out_green_first;
  byte_t out_blue_first;
  byte_t out_red_second;
  byte_t out_green_second;
  byte_t out_blue_second;
  logic  out_end_of_frame_out;

  rgb_pair_scoreboard board = new();

  // Traffic shaping, written by the main sequence only.
  int sender_idle_pct  = 0;
  int sink_stall_pct   = 0;
  int holdoff_requests = 0;

  yuyv_to_rgb888_converter i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_luma_first        (in_luma_first),
    .in_chroma_blue       (in_chroma_blue),
    .in_luma_second       (in_luma_second),
    .in_chroma_red        (in_chroma_red),
    .in_end_of_frame      (in_end_of_frame),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_red_first        (out_red_first),
    .out_green_first      (out_green_first),
    .out_blue_first       (out_blue_first),
    .out_red_second       (out_red_second),
    .out_green_second     (out_green_second),
    .out_blue_second      (out_blue_second),
    .out_end_of_frame_out (out_end_of_frame_out)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Bias each byte toward the corners and the neutral point so that the clamps
  // and the zero-chroma path are hit often, while the rest stays uniform.
  function automatic byte_t pick_byte();
    case ($urandom_range(7))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return byte_t'($urandom_range(136, 120));
      default: return byte_t'($urandom_range(255));
    endcase
  endfunction

  function automatic yuyv_word_t random_word();
    yuyv_word_t w;
    w.luma_first   = pick_byte();
    w.chroma_blue  = pick_byte();
    w.luma_second  = pick_byte();
    w.chroma_red   = pick_byte();
    w.end_of_frame = ($urandom_range(15) == 0);
    return w;
  endfunction

  function automatic yuyv_word_t make_word(byte_t y0, byte_t u, byte_t y1, byte_t v,
                                           logic eof);
    yuyv_word_t w;
    w.luma_first   = y0;
    w.chroma_blue  = u;
    w.luma_second  = y1;
    w.chroma_red   = v;
    w.end_of_frame = eof;
    return w;
  endfunction

  // Offer one word, hold it until the block takes it, then log it as accepted.
  // The inter-word gap follows, so in_valid is only lowered when a gap is drawn.
  task automatic send_word(yuyv_word_t w);
    int gap;
    in_valid        <= 1'b1;
    in_luma_first   <= w.luma_first;
    in_chroma_blue  <= w.chroma_blue;
    in_luma_second  <= w.luma_second;
    in_chroma_red   <= w.chroma_red;
    in_end_of_frame <= w.end_of_frame;
    do @(posedge clk); while (!in_ready);
    board.note_word(w);
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic run_phase(int words, int idle_pct, int stall_pct);
    sender_idle_pct = idle_pct;
    sink_stall_pct  = stall_pct;
    repeat (words) send_word(random_word());
  endtask

  // Drop valid and wait until every pending pair has come out.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (board.pending_pairs.size() != 0) @(posedge clk);
  endtask

  // Receiver: stall at the current rate; serve a long hold-off on request.
  initial begin
    int holdoff_served;
    int holdoff_left;
    holdoff_served = 0;
    holdoff_left   = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holdoff_left == 0 && holdoff_served != holdoff_requests) begin
        holdoff_served = holdoff_requests;
        holdoff_left   = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Result monitor: signals read right after the edge hold their pre-edge values.
  always @(posedge clk) begin
    rgb_pair_t got;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      got.red_first    = out_red_first;
      got.green_first  = out_green_first;
      got.blue_first   = out_blue_first;
      got.red_second   = out_red_second;
      got.green_second = out_green_second;
      got.blue_second  = out_blue_second;
      got.end_of_frame = out_end_of_frame_out;
      board.check_pair(got);
    end
  end

  // Watchdog: end the run if no transaction moves on either side for too long.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_ready === 1'b1) ||
          (out_valid === 1'b1 && out_ready === 1'b1))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_luma_first   <= '0;
    in_chroma_blue  <= '0;
    in_luma_second  <= '0;
    in_chroma_red   <= '0;
    in_end_of_frame <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words: corners of every byte, neutral chroma, clamps both ways,
    // end-of-frame flag on and off, alternating bit patterns.
    sender_idle_pct = 0;
    sink_stall_pct  = 0;
    send_word(make_word(8'd0,   8'd0,   8'd0,   8'd0,   1'b0));
    send_word(make_word(8'd255, 8'd255, 8'd255, 8'd255, 1'b1));
    send_word(make_word(8'd0,   8'd128, 8'd255, 8'd128, 1'b0)); // gray ramp ends
    send_word(make_word(8'd16,  8'd128, 8'd235, 8'd128, 1'b0));
    send_word(make_word(8'd255, 8'd255, 8'd200, 8'd255, 1'b0)); // red/blue overflow
    send_word(make_word(8'd0,   8'd0,   8'd30,  8'd0,   1'b0)); // red/blue underflow
    send_word(make_word(8'd0,   8'd255, 8'd10,  8'd255, 1'b0)); // green underflow
    send_word(make_word(8'd255, 8'd0,   8'd240, 8'd0,   1'b1)); // green overflow
    send_word(make_word(8'd128, 8'd129, 8'd127, 8'd127, 1'b0)); // tiny chroma steps
    send_word(make_word(8'd170, 8'd85,  8'd85,  8'd170, 1'b0));
    send_word(make_word(8'd85,  8'd170, 8'd170, 8'd85,  1'b1));
    send_word(make_word(8'd1,   8'd254, 8'd254, 8'd1,   1'b0));
    send_word(make_word(8'd81,  8'd90,  8'd145, 8'd240, 1'b0)); // saturated red
    send_word(make_word(8'd41,  8'd240, 8'd210, 8'd110, 1'b0)); // blue, then pale blue
    send_word(make_word(8'd255, 8'd128, 8'd0,   8'd128, 1'b1));
    send_word(make_word(8'd200, 8'd0,   8'd60,  8'd255, 1'b0));

    // Random traffic under the different idling patterns.
    run_phase(400, 0, 0);
    run_phase(350, 85, 0);
    run_phase(350, 0, 85);
    run_phase(400, 6, 6);

    // Pressure: hold the receiver off while the sender keeps pushing, so the
    // pipeline fills and in_ready drops; then pause until everything drains.
    holdoff_requests++;
    run_phase(200, 0, 0);
    drain_pipeline();
    run_phase(150, 6, 6);

    drain_pipeline();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.failures() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
